// File: hw/rtl/n2a_pkg.sv
// ----------------------------------------------------------------------------
// n2a_pkg
// Shared types and constants of the number to ASCII formatter.
// ----------------------------------------------------------------------------
package n2a_pkg;

   localparam int OPCODE_W = 2;
   localparam int VALUE_W  = 32;
   localparam int CHAR_W   = 7;

   // Input format selector codes
   localparam logic [OPCODE_W-1:0] OPC_HEX16 = 2'd0;
   localparam logic [OPCODE_W-1:0] OPC_HEX32 = 2'd1;
   localparam logic [OPCODE_W-1:0] OPC_DEC16 = 2'd2;
   localparam logic [OPCODE_W-1:0] OPC_RSVD  = 2'd3;

   // ASCII codes
   localparam logic [CHAR_W-1:0] CH_SPACE          = 7'h20;
   localparam logic [CHAR_W-1:0] CH_ZERO           = 7'h30;
   localparam logic [CHAR_W-1:0] CH_X              = 7'h78;
   localparam logic [CHAR_W-1:0] HEX_LETTER_OFFSET = 7'h37;

   // Decimal conversion: five digits, floor(x/10) = (x * 0xCCCD) >> 19 for 16-bit x
   localparam int                DEC_DIGITS = 5;
   localparam int                CNT_W      = $clog2(DEC_DIGITS + 1);
   localparam logic [16:0]       RECIP_TEN  = 17'd52429;
   localparam int                RECIP_SHR  = 19;

   // Job queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Character index within one item's text (at most twelve characters)
   localparam int IDX_W = 4;

   typedef enum logic [1:0] {
      FMT_HEX16,
      FMT_HEX32,
      FMT_DEC
   } n2a_fmt_type;

   // One classified job: hex formats carry the value, decimal carries five
   // BCD digits with digit i (units first) at bits 4i+3:4i.
   typedef struct packed {
      n2a_fmt_type        fmt;
      logic [VALUE_W-1:0] data;
   } n2a_job_type;

endpackage

// File: hw/rtl/n2a_channels.sv
// ----------------------------------------------------------------------------
// n2a_channels
// Valid/ready channel interfaces for request and response words.
// ----------------------------------------------------------------------------
interface n2a_req_if;
   import n2a_pkg::*;
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [VALUE_W-1:0]  value;

   modport source (output valid, output opcode, output value, input ready);
   modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface n2a_rsp_if;
   import n2a_pkg::*;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] ascii_char;
   logic              last;

   modport source (output valid, output ascii_char, output last, input ready);
   modport sink   (input valid, input ascii_char, input last, output ready);
endinterface

// File: hw/rtl/n2a_front.sv
// ----------------------------------------------------------------------------
// n2a_front
// Accept request words, classify the format and convert decimal values to
// BCD, one digit per cycle.
// ----------------------------------------------------------------------------
module n2a_front (
   input  logic              clock,
   input  logic              reset,
   n2a_req_if.sink           req_chan,
   output logic              push_valid,
   input  logic              push_ready,
   output n2a_pkg::n2a_job_type push_job
);
   import n2a_pkg::*;

   logic               fe_valid_ff, fe_valid_in;
   logic [CNT_W-1:0]   fe_cnt_ff, fe_cnt_in;
   n2a_fmt_type        fe_fmt_ff, fe_fmt_in;
   logic [15:0]        fe_work_ff, fe_work_in;
   logic [VALUE_W-1:0] fe_data_ff, fe_data_in;

   logic               accept;
   logic               push;
   logic [32:0]        prod;
   logic [15:0]        quot;
   logic [15:0]        rem;
   n2a_fmt_type        new_fmt;

   assign push           = fe_valid_ff && (fe_cnt_ff == '0) && push_ready;
   assign req_chan.ready = !fe_valid_ff || push;
   assign accept         = req_chan.valid && req_chan.ready;

   assign push_valid    = fe_valid_ff && (fe_cnt_ff == '0);
   assign push_job.fmt  = fe_fmt_ff;
   assign push_job.data = fe_data_ff;

   // Digit step: quotient by reciprocal, remainder by shift-add
   assign prod = {1'b0, fe_work_ff} * {16'd0, RECIP_TEN};
   assign quot = {2'd0, prod[32:RECIP_SHR]};
   assign rem  = fe_work_ff - ({quot[12:0], 3'b000} + {quot[14:0], 1'b0});

   always_comb begin
      unique case (req_chan.opcode) inside
         OPC_HEX16:           new_fmt = FMT_HEX16;
         OPC_HEX32:           new_fmt = FMT_HEX32;
         OPC_DEC16, OPC_RSVD: new_fmt = FMT_DEC;
         default:             new_fmt = FMT_DEC;
      endcase
   end

   always_comb begin
      fe_valid_in = fe_valid_ff;
      fe_cnt_in   = fe_cnt_ff;
      fe_fmt_in   = fe_fmt_ff;
      fe_work_in  = fe_work_ff;
      fe_data_in  = fe_data_ff;
      if (push) begin
         fe_valid_in = 1'b0;
      end
      if (accept) begin
         fe_valid_in = 1'b1;
         fe_fmt_in   = new_fmt;
         fe_work_in  = req_chan.value[15:0];
         if (new_fmt == FMT_HEX32) begin
            fe_data_in = req_chan.value;
         end else begin
            fe_data_in = {16'd0, req_chan.value[15:0]};
         end
         fe_cnt_in = (new_fmt == FMT_DEC) ? CNT_W'(DEC_DIGITS) : '0;
      end else if (fe_valid_ff && (fe_cnt_ff != '0)) begin
         // shift the new digit in at the top; units end up at the bottom
         fe_work_in = quot;
         fe_data_in = {12'd0, rem[3:0], fe_data_ff[19:4]};
         fe_cnt_in  = fe_cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fe_valid_ff <= 1'b0;
         fe_cnt_ff   <= '0;
      end else begin
         fe_valid_ff <= fe_valid_in;
         fe_cnt_ff   <= fe_cnt_in;
      end
      fe_fmt_ff  <= fe_fmt_in;
      fe_work_ff <= fe_work_in;
      fe_data_ff <= fe_data_in;
   end

endmodule

// File: hw/rtl/n2a_queue.sv
// ----------------------------------------------------------------------------
// n2a_queue
// Short job queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module n2a_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  n2a_pkg::n2a_job_type push_job,
   output logic                 pop_valid,
   input  logic                 pop,
   output n2a_pkg::n2a_job_type pop_job
);
   import n2a_pkg::*;

   n2a_job_type       entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + QPTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: hw/rtl/n2a_back.sv
// ----------------------------------------------------------------------------
// n2a_back
// Serialize one job into ASCII characters through the output register.
// ----------------------------------------------------------------------------
module n2a_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop,
   input  n2a_pkg::n2a_job_type pop_job,
   n2a_rsp_if.source            rsp_chan
);
   import n2a_pkg::*;

   logic               be_valid_ff, be_valid_in;
   n2a_job_type        be_job_ff, be_job_in;
   logic [IDX_W-1:0]   be_idx_ff, be_idx_in;
   logic               out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]  out_char_ff, out_char_in;
   logic               out_last_ff, out_last_in;

   logic [CHAR_W-1:0]  cur_char;
   logic               cur_last;
   logic               advance;
   logic               load;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] nib);
      if (nib >= 4'hA) begin
         return {3'd0, nib} + HEX_LETTER_OFFSET;
      end
      return {3'd0, nib} + CH_ZERO;
   endfunction

   // Character and end mark at position idx of a job's text
   function automatic logic [CHAR_W:0] job_char(input n2a_job_type job,
                                               input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0]  last_idx;
      logic [IDX_W-1:0]  nib_sel;
      logic [CHAR_W-1:0] ch;
      unique case (job.fmt)
         FMT_HEX16: begin
            last_idx = IDX_W'(7);
            nib_sel  = IDX_W'(6) - idx;
         end
         FMT_HEX32: begin
            last_idx = IDX_W'(11);
            nib_sel  = IDX_W'(10) - idx;
         end
         default: begin
            last_idx = IDX_W'(6);
            nib_sel  = IDX_W'(5) - idx;
         end
      endcase
      if ((idx == '0) || (idx == last_idx)) begin
         ch = CH_SPACE;
      end else if ((job.fmt != FMT_DEC) && (idx == IDX_W'(1))) begin
         ch = CH_ZERO;
      end else if ((job.fmt != FMT_DEC) && (idx == IDX_W'(2))) begin
         ch = CH_X;
      end else begin
         ch = digit_char(job.data[{nib_sel[2:0], 2'b00} +: 4]);
      end
      return {ch, (idx == last_idx)};
   endfunction

   assign {cur_char, cur_last} = job_char(be_job_ff, be_idx_ff);

   assign advance = be_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign load    = !be_valid_ff || (advance && cur_last);
   assign pop     = load && pop_valid;

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.ascii_char = out_char_ff;
   assign rsp_chan.last       = out_last_ff;

   always_comb begin
      be_valid_in  = be_valid_ff;
      be_job_in    = be_job_ff;
      be_idx_in    = be_idx_ff;
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_char_in  = cur_char;
         out_last_in  = cur_last;
         be_idx_in    = be_idx_ff + IDX_W'(1);
      end
      if (load) begin
         be_valid_in = pop_valid;
         be_job_in   = pop_job;
         be_idx_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         be_valid_ff  <= 1'b0;
         be_idx_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         be_valid_ff  <= be_valid_in;
         be_idx_ff    <= be_idx_in;
         out_valid_ff <= out_valid_in;
      end
      be_job_ff   <= be_job_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

endmodule

// File: hw/rtl/number_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// number_to_ascii_formatter
// Turn a format selector and a 32-bit value into ASCII text, one character
// per response word.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries opcode and value; a word moves when valid and ready are
//   both high. Opcode 0 prints " 0xHHHH " (8 chars), 1 prints " 0xHHHHHHHH "
//   (12 chars), 2 and 3 print " DDDDD " (7 chars, leading zeros kept).
//   rsp_chan returns one character per word; last marks the final one.
// Path: a word goes from the front register through the job queue and the
//   back job register to the output register; a decimal word first takes
//   five digit steps in the front.
// Throughput: one character per cycle from the output register while rsp
//   ready is high. The front converts the next word while the back is still
//   emitting the previous one, with a two-entry job queue in between.
// Reset: clears all valid flags; no word is pending afterwards.
// Stall: when rsp ready is low the output register holds its character,
//   the back end waits, the queue fills, and then req ready drops.
// ----------------------------------------------------------------------------
module number_to_ascii_formatter (
   input  logic       clock,
   input  logic       reset,
   n2a_req_if.sink    req_chan,
   n2a_rsp_if.source  rsp_chan
);
   import n2a_pkg::*;

   // Front to queue
   logic        push_valid;
   logic        push_ready;
   n2a_job_type push_job;

   // Queue to back
   logic        pop_valid;
   logic        pop;
   n2a_job_type pop_job;

   // Accept, classify and convert to BCD
   n2a_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   // Hold classified jobs so front and back stall on their own
   n2a_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_job    (pop_job)
   );

   // Emit characters one per cycle while the response side is ready
   n2a_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop       (pop),
      .pop_job   (pop_job),
      .rsp_chan  (rsp_chan)
   );

endmodule

// File: tb/sv/tb_number_to_ascii_formatter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_number_to_ascii_formatter
// Self-checking bench: drives format/value words, predicts the ASCII text and
// checks every returned character and its last flag, under varied idling.
// ----------------------------------------------------------------------------
module tb_number_to_ascii_formatter;
   import n2a_pkg::*;

   localparam int RESET_CYCLES     = 10;
   localparam int WORDS_PER_PHASE  = 40;
   localparam int PHASES           = 5;
   localparam int PRESSURE_PHASE   = 4;
   localparam int HOLD_OFF_CYCLES  = 300;
   localparam int DRAIN_CYCLES     = 20;
   localparam int CYCLE_LIMIT      = 400000;
   localparam int MAX_REPORTS      = 10;

   // One expected response word: a character and its end-of-text flag
   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } char_word_type;

   // One directed row; an empty text means "ask the text predictor"
   typedef struct {
      logic [OPCODE_W-1:0] opcode;
      logic [VALUE_W-1:0]  value;
      string               text;
   } stim_row_type;

   logic clock;
   logic reset;

   n2a_req_if req_chan ();
   n2a_rsp_if rsp_chan ();

   number_to_ascii_formatter dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   char_word_type pending_chars[$];
   stim_row_type  directed_rows[$];
   char_word_type want;

   int  src_idle_pct  = 0;
   int  rsp_stall_pct = 0;
   bit  hold_armed    = 1'b0;
   bit  hold_taken    = 1'b0;
   int  hold_left     = 0;
   int  mismatches    = 0;
   int  cycles        = 0;

   // Sender idle and receiver stall percentages of each random phase:
   // none, sender idle, receiver stall, both, then the long hold-off.
   int idle_by_phase  [PHASES] = '{0, 84, 0, 37, 0};
   int stall_by_phase [PHASES] = '{0, 0, 84, 37, 0};

   always #1 clock = ~clock;

   // Append one character to the expected text stream.
   function automatic void push_char(logic [CHAR_W-1:0] ch, logic last);
      char_word_type w;
      w.ch   = ch;
      w.last = last;
      pending_chars.push_back(w);
   endfunction

   // Queue a literal expected text, marking its final character as last.
   function automatic void push_text(string s);
      byte b;
      for (int i = 0; i < s.len(); i++) begin
         b = s[i];
         push_char(b[CHAR_W-1:0], i == s.len() - 1);
      end
   endfunction

   // Work out the text of one accepted word and queue it.
   function automatic void predict_text(logic [OPCODE_W-1:0] op, logic [VALUE_W-1:0] val);
      logic [CHAR_W-1:0] txt[$];
      logic [3:0]        nib;
      int                ndig;
      int                rest;
      int                div;
      txt.push_back(CH_SPACE);
      if (op == OPC_HEX16 || op == OPC_HEX32) begin
         ndig = (op == OPC_HEX32) ? 8 : 4;
         txt.push_back(CH_ZERO);
         txt.push_back(CH_X);
         for (int d = ndig - 1; d >= 0; d--) begin
            nib = val[4*d +: 4];
            txt.push_back((nib < 4'd10) ? CH_ZERO + CHAR_W'(nib)
                                        : HEX_LETTER_OFFSET + CHAR_W'(nib));
         end
      end else begin
         // decimal and the reserved selector: five digits of the low half
         rest = int'(val[15:0]);
         div  = 10000;
         for (int d = 0; d < 5; d++) begin
            txt.push_back(CH_ZERO + CHAR_W'((rest / div) % 10));
            div = div / 10;
         end
      end
      txt.push_back(CH_SPACE);
      foreach (txt[i])
         push_char(txt[i], i == txt.size() - 1);
   endfunction

   function automatic void add_row(logic [OPCODE_W-1:0] op, logic [VALUE_W-1:0] val,
                                   string text);
      stim_row_type r;
      r.opcode = op;
      r.value  = val;
      r.text   = text;
      directed_rows.push_back(r);
   endfunction

   // Offer one request word, starting at a falling edge; idle first at the
   // sender's rate, hold the word until it is taken, then queue its text.
   task automatic send_word(logic [OPCODE_W-1:0] op, logic [VALUE_W-1:0] val, string text);
      while ($urandom_range(99) < src_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.opcode <= op;
      req_chan.value  <= val;
      do
         @(posedge clock);
      while (!req_chan.ready);
      if (text.len() == 0)
         predict_text(op, val);
      else
         push_text(text);
      @(negedge clock);
   endtask

   // Main stimulus: reset, directed rows, then the random phases.
   initial begin
      logic [OPCODE_W-1:0] op;
      logic [VALUE_W-1:0]  val;
      clock           = 1'b0;
      reset           = 1'b1;
      req_chan.valid  = 1'b0;
      req_chan.opcode = OPC_HEX16;
      req_chan.value  = '0;

      // Extremes of both fields, every selector, upper half ignored by the
      // 16-bit formats, reserved selector printing like decimal.
      add_row(OPC_HEX16, 32'h0000_0000, " 0x0000 ");
      add_row(OPC_HEX16, 32'h0000_FFFF, " 0xFFFF ");
      add_row(OPC_HEX16, 32'hFFFF_0000, " 0x0000 ");
      add_row(OPC_HEX16, 32'h1234_5ABC, " 0x5ABC ");
      add_row(OPC_HEX32, 32'h0000_0000, " 0x00000000 ");
      add_row(OPC_HEX32, 32'hFFFF_FFFF, " 0xFFFFFFFF ");
      add_row(OPC_HEX32, 32'h0123_4567, " 0x01234567 ");
      add_row(OPC_HEX32, 32'h89AB_CDEF, " 0x89ABCDEF ");
      add_row(OPC_HEX32, 32'hA5A5_5A5A, "");
      add_row(OPC_DEC16, 32'd0,         " 00000 ");
      add_row(OPC_DEC16, 32'd65535,     " 65535 ");
      add_row(OPC_DEC16, 32'hFFFF_0000, " 00000 ");
      add_row(OPC_DEC16, 32'h0001_0009, " 00009 ");
      add_row(OPC_DEC16, 32'd10,        " 00010 ");
      add_row(OPC_DEC16, 32'd12345,     " 12345 ");
      add_row(OPC_DEC16, 32'hDEAD_BEEF, "");
      add_row(OPC_DEC16, 32'd9999,      "");
      add_row(OPC_RSVD,  32'd0,         " 00000 ");
      add_row(OPC_RSVD,  32'hFFFF_FFFF, " 65535 ");
      add_row(OPC_RSVD,  32'hABCD_1234, "");

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_word(directed_rows[i].opcode, directed_rows[i].value, directed_rows[i].text);

      for (int ph = 0; ph < PHASES; ph++) begin
         src_idle_pct  = idle_by_phase[ph];
         rsp_stall_pct = stall_by_phase[ph];
         // arm the long receiver hold-off; the sender keeps offering words
         // so the job queue fills and request ready drops
         if (ph == PRESSURE_PHASE)
            hold_armed = 1'b1;
         repeat (WORDS_PER_PHASE) begin
            op = OPCODE_W'($urandom_range(3));
            case ($urandom_range(3))
               0: val = $urandom;
               1: val = VALUE_W'($urandom_range(999));
               2: val = {16'($urandom), 16'hFFFF - 16'($urandom_range(15))};
               default: val = {16'($urandom), 16'($urandom_range(99999) % 65536)};
            endcase
            send_word(op, val, "");
         end
      end
      req_chan.valid <= 1'b0;

      // Drain the outstanding text, then watch for stray characters.
      while (pending_chars.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // Response side: drive ready at the falling edge, honoring the one-shot
   // hold-off before falling back to the phase's stall rate.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_armed && !hold_taken) begin
            hold_left  = HOLD_OFF_CYCLES;
            hold_taken = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Check each accepted character against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_chars.size() == 0) begin
            if (mismatches < MAX_REPORTS)
               $display("unexpected char 0x%02h last=%0b at cycle %0d",
                        rsp_chan.ascii_char, rsp_chan.last, cycles);
            mismatches++;
         end else begin
            want = pending_chars.pop_front();
            if (rsp_chan.ascii_char !== want.ch || rsp_chan.last !== want.last) begin
               if (mismatches < MAX_REPORTS)
                  $display("char mismatch at cycle %0d: want 0x%02h last=%0b, got 0x%02h last=%0b",
                           cycles, want.ch, want.last, rsp_chan.ascii_char, rsp_chan.last);
               mismatches++;
            end
         end
      end
   end

   // Bound the run.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

endmodule
